// ===== rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and codes shared by the periodic and timeout timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_START_PER = 2'd1,
		OP_START_TMO = 2'd2,
		OP_CLR_TERM  = 2'd3
	} op_t;

	localparam logic CFG_PER_IN_USE = 1'b0;
	localparam logic CFG_TMO_IN_USE = 1'b1;

	localparam int unsigned USE_BITS   = 4;
	localparam logic [USE_BITS-1:0] USE_RESET = 4'd8;
	localparam int unsigned OUT_BITS   = 8;
	localparam int unsigned TICKS_BITS = 16;

	typedef struct packed {
		op_t                   op;
		logic [2:0]            index;
		logic [TICKS_BITS-1:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] terminal_flags;
		logic [OUT_BITS-1:0] timeouts_running;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic issue;
		logic drain;
	} walk_t;

endpackage

// ===== rtl/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int unsigned DW    = 16,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ptt_walk.sv =====
// ----------------------------------------------------------------------------
// ptt_walk
// Tick sequencer: steps an entry index over the tables, one entry a cycle.
// ----------------------------------------------------------------------------
module ptt_walk
	import ptt_pkg::*;
#(
	parameter int unsigned LEN = 8,
	parameter int unsigned IW  = (LEN > 1) ? $clog2(LEN) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	output walk_t         walk,
	output logic [IW-1:0] idx
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] idx_q;
	logic          last;

	assign last = (idx_q == IW'(LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (go) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (last) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idx        = idx_q;
	assign walk.busy  = (state_q != S_IDLE);
	assign walk.issue = (state_q == S_WALK);
	assign walk.drain = (state_q == S_DRAIN);

	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && last |=> (state_q == S_DRAIN))
		else $error("walk did not drain after last entry");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (32'(idx_q) < LEN))
		else $error("walk index out of range");

	a_go_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && go |=> (state_q == S_WALK) && (idx_q == '0))
		else $error("walk did not start at entry zero");

endmodule

// ===== rtl/periodic_and_timeout_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_table_core
// Periodic timer and one-shot timeout tables held in two synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  command   in   start & !busy        cmd   (op, index, ticks)
//  result    out  done, one cycle     rsp   (terminal_flags, timeouts_running)
//  config    in   cfg_we              cfg_idx, cfg_wdata
//
//  Ops 1 to 3 start no walk; done follows on the next cycle and busy stays low.
//  A tick walks max(NUM_PERIODIC, NUM_TIMEOUTS) entries, one a cycle through
//  the RAM read port, then a drain state writes back the last entry. busy
//  stays high through the walk and the drain; done follows the drain.
//  Reset clears active, terminal and running bits; RAM contents are read only
//  once written. done cannot be held off.
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_table_core
	import ptt_pkg::*;
#(
	parameter int unsigned NUM_PERIODIC = 8,
	parameter int unsigned NUM_TIMEOUTS = 8,
	parameter int unsigned COUNT_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_t                cmd,
	output logic                done,
	output rsp_t                rsp,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [USE_BITS-1:0] cfg_wdata
);

	localparam int unsigned LEN = (NUM_PERIODIC > NUM_TIMEOUTS) ? NUM_PERIODIC : NUM_TIMEOUTS;
	localparam int unsigned IW  = (LEN > 1) ? $clog2(LEN) : 1;
	localparam int unsigned PW  = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
	localparam int unsigned TW  = (NUM_TIMEOUTS > 1) ? $clog2(NUM_TIMEOUTS) : 1;
	localparam int unsigned CB  = COUNT_BITS;

	logic [USE_BITS-1:0]   per_use_q;
	logic [USE_BITS-1:0]   tmo_use_q;
	logic [NUM_PERIODIC-1:0] active_q;
	logic [NUM_PERIODIC-1:0] term_q;
	logic [NUM_TIMEOUTS-1:0] run_q;
	logic                  done_q;

	walk_t                 walk;
	logic [IW-1:0]         idx;
	logic [IW-1:0]         idx_s1;
	logic                  p_vld_s1;
	logic                  t_vld_s1;

	logic                  acc;
	logic                  op1_go;
	logic                  op2_go;
	logic                  op3_go;
	logic [CB-1:0]         t;

	logic                  p_rd;
	logic                  t_rd;
	logic                  p_we;
	logic [PW-1:0]         p_waddr;
	logic [2*CB-1:0]       p_wdata;
	logic [2*CB-1:0]       p_rdata;
	logic [CB-1:0]         p_period;
	logic [CB-1:0]         p_dec;
	logic                  p_fire;
	logic [CB-1:0]         p_next;
	logic                  t_we;
	logic [TW-1:0]         t_waddr;
	logic [CB-1:0]         t_wdata;
	logic [CB-1:0]         t_rdata;
	logic [CB-1:0]         t_dec;

	assign busy   = walk.busy;
	assign acc    = start && !busy;
	assign t      = CB'(cmd.ticks);
	assign op1_go = acc && (cmd.op == OP_START_PER) && (32'(cmd.index) < NUM_PERIODIC);
	assign op2_go = acc && (cmd.op == OP_START_TMO) && (32'(cmd.index) < NUM_TIMEOUTS);
	assign op3_go = acc && (cmd.op == OP_CLR_TERM) && (32'(cmd.index) < NUM_PERIODIC);

	ptt_walk #(
		.LEN (LEN)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (acc && (cmd.op == OP_TICK)),
		.walk   (walk),
		.idx    (idx)
	);

	assign p_rd = walk.issue && (32'(idx) < 32'(per_use_q)) && (32'(idx) < NUM_PERIODIC)
		&& active_q[idx[PW-1:0]];
	assign t_rd = walk.issue && (32'(idx) < 32'(tmo_use_q)) && (32'(idx) < NUM_TIMEOUTS)
		&& run_q[idx[TW-1:0]];

	assign p_period = p_rdata[2*CB-1:CB];
	assign p_dec    = p_rdata[CB-1:0] - CB'(1);
	assign p_fire   = (p_dec == '0);
	assign p_next   = p_fire ? p_period : p_dec;
	assign t_dec    = t_rdata - CB'(1);

	assign p_we    = p_vld_s1 || op1_go;
	assign p_waddr = p_vld_s1 ? idx_s1[PW-1:0] : PW'(cmd.index);
	assign p_wdata = p_vld_s1 ? {p_period, p_next} : {t, t};
	assign t_we    = t_vld_s1 || op2_go;
	assign t_waddr = t_vld_s1 ? idx_s1[TW-1:0] : TW'(cmd.index);
	assign t_wdata = t_vld_s1 ? t_dec : t;

	ptt_ram #(
		.DW    (2 * CB),
		.DEPTH (NUM_PERIODIC)
	) u_per_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_rd),
		.raddr (idx[PW-1:0]),
		.rdata (p_rdata)
	);

	ptt_ram #(
		.DW    (CB),
		.DEPTH (NUM_TIMEOUTS)
	) u_tmo_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_rd),
		.raddr (idx[TW-1:0]),
		.rdata (t_rdata)
	);

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_use_q <= USE_RESET;
			tmo_use_q <= USE_RESET;
			active_q  <= '0;
			term_q    <= '0;
			run_q     <= '0;
			p_vld_s1  <= 1'b0;
			t_vld_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			p_vld_s1 <= p_rd;
			t_vld_s1 <= t_rd;
			done_q   <= (acc && (cmd.op != OP_TICK)) || walk.drain;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PER_IN_USE: per_use_q <= cfg_wdata;
					CFG_TMO_IN_USE: tmo_use_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (p_vld_s1 && p_fire) begin
				term_q[idx_s1[PW-1:0]] <= 1'b1;
			end
			if (t_vld_s1) begin
				run_q[idx_s1[TW-1:0]] <= (t_dec != '0);
			end
			if (op1_go) begin
				active_q[PW'(cmd.index)] <= 1'b1;
			end
			if (op2_go) begin
				run_q[TW'(cmd.index)] <= (t != '0);
			end
			if (op3_go) begin
				term_q[PW'(cmd.index)] <= 1'b0;
			end
		end
	end

	assign done = done_q;

	for (genvar g = 0; g < OUT_BITS; g++) begin : g_out
		if (g < NUM_PERIODIC) begin : g_p
			assign rsp.terminal_flags[g] = term_q[g];
		end else begin : g_pz
			assign rsp.terminal_flags[g] = 1'b0;
		end
		if (g < NUM_TIMEOUTS) begin : g_t
			assign rsp.timeouts_running[g] = run_q[g];
		end else begin : g_tz
			assign rsp.timeouts_running[g] = 1'b0;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.op == OP_TICK) |=> busy)
		else $error("tick accepted without walk");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		walk.drain |=> done)
		else $error("walk finished without result beat");

	a_no_cmd_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(p_vld_s1 || t_vld_s1) |-> !acc)
		else $error("command write collides with walk write-back");

endmodule

// ===== tb/sv/timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches the command, result and register channels of the timer table core.
// Keeps its own copy of the periodic and timeout tables, works out the
// status word that each accepted command beat should return, and compares
// every result beat with the oldest outstanding status.
// ----------------------------------------------------------------------------
module timer_table_checker
	import ptt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  cmd_t                cmd,
	input  logic                done,
	input  rsp_t                rsp,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [USE_BITS-1:0] cfg_wdata,
	output int                  pending,
	output int                  mismatches
);

	localparam int unsigned ENTRIES = 8;

	logic [USE_BITS-1:0]   per_use;
	logic [USE_BITS-1:0]   tmo_use;
	logic [ENTRIES-1:0]    active;
	logic [ENTRIES-1:0]    terminal;
	logic [TICKS_BITS-1:0] remaining [ENTRIES];
	logic [TICKS_BITS-1:0] reload    [ENTRIES];
	logic [TICKS_BITS-1:0] tmo_left  [ENTRIES];
	rsp_t                  status_q  [$];
	int                    mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic clear_tables();
		per_use  = USE_RESET;
		tmo_use  = USE_RESET;
		active   = '0;
		terminal = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			remaining[i] = '0;
			reload[i]    = '0;
			tmo_left[i]  = '0;
		end
	endtask

	task automatic tick_tables();
		int np;
		int nt;
		np = (per_use > ENTRIES) ? ENTRIES : per_use;
		nt = (tmo_use > ENTRIES) ? ENTRIES : tmo_use;
		for (int i = 0; i < np; i++) begin
			if (active[i]) begin
				remaining[i] = remaining[i] - 1'b1;
				if (remaining[i] == '0) begin
					terminal[i]  = 1'b1;
					remaining[i] = reload[i];
				end
			end
		end
		for (int i = 0; i < nt; i++) begin
			if (tmo_left[i] != '0)
				tmo_left[i] = tmo_left[i] - 1'b1;
		end
	endtask

	task automatic apply_command(cmd_t c);
		case (c.op)
			OP_TICK: begin
				tick_tables();
			end
			OP_START_PER: begin
				active[c.index]    = 1'b1;
				reload[c.index]    = c.ticks;
				remaining[c.index] = c.ticks;
			end
			OP_START_TMO: begin
				tmo_left[c.index] = c.ticks;
			end
			OP_CLR_TERM: begin
				terminal[c.index] = 1'b0;
			end
			default: begin
				report_mismatch($sformatf("unknown op %b accepted", c.op));
			end
		endcase
	endtask

	function automatic rsp_t table_status();
		rsp_t s;
		s.terminal_flags = terminal;
		for (int i = 0; i < ENTRIES; i++)
			s.timeouts_running[i] = (tmo_left[i] != '0);
		return s;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			clear_tables();
			status_q.delete();
		end else begin
			if (done) begin
				if (status_q.size() == 0) begin
					report_mismatch("result beat with no status outstanding");
				end else begin
					want = status_q.pop_front();
					if (rsp.terminal_flags !== want.terminal_flags)
						report_mismatch($sformatf("terminal_flags got %h want %h",
							rsp.terminal_flags, want.terminal_flags));
					if (rsp.timeouts_running !== want.timeouts_running)
						report_mismatch($sformatf("timeouts_running got %h want %h",
							rsp.timeouts_running, want.timeouts_running));
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_PER_IN_USE)
					per_use = cfg_wdata;
				else
					tmo_use = cfg_wdata;
			end
			if (start && !busy) begin
				apply_command(cmd);
				status_q.push_back(table_status());
			end
		end
		pending <= status_q.size();
	end

endmodule

// ===== tb/sv/tb_periodic_and_timeout_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_and_timeout_timer_table_core
// Drives command beats and in-use register writes into the timer table core.
// A short directed run covers the counter extremes, zero and wrapping
// periods, restarts and flag clears; random phases with different in-use
// settings and random idle gaps follow. The checker beside the core does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_periodic_and_timeout_timer_table_core;
	import ptt_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASES        = 7;
	localparam int unsigned PHASE_BEATS   = 160;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	cmd_t                cmd       = '0;
	logic                cfg_we    = 1'b0;
	logic                cfg_idx   = CFG_PER_IN_USE;
	logic [USE_BITS-1:0] cfg_wdata = '0;
	logic                busy;
	logic                done;
	rsp_t                rsp;
	int                  pending;
	int                  mismatches;
	bit                  no_gaps   = 1'b0;

	periodic_and_timeout_timer_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	timer_table_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic cmd_t make_cmd(op_t o, logic [2:0] idx, logic [TICKS_BITS-1:0] t);
		cmd_t c;
		c.op    = o;
		c.index = idx;
		c.ticks = t;
		return c;
	endfunction

	function automatic logic [TICKS_BITS-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return TICKS_BITS'($urandom_range(0, 6));
		else if (r < 90)
			return TICKS_BITS'($urandom_range(7, 40));
		return TICKS_BITS'($urandom_range(0, 65535));
	endfunction

	function automatic cmd_t random_cmd();
		int   r;
		op_t  o;
		r = $urandom_range(0, 99);
		if (r < 45)
			o = OP_TICK;
		else if (r < 65)
			o = OP_START_PER;
		else if (r < 85)
			o = OP_START_TMO;
		else
			o = OP_CLR_TERM;
		return make_cmd(o, 3'($urandom_range(0, 7)), pick_ticks());
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue(cmd_t c);
		int gap;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_use(logic [USE_BITS-1:0] per, logic [USE_BITS-1:0] tmo);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_PER_IN_USE;
		cfg_wdata <= per;
		@(posedge clk);
		cfg_idx   <= CFG_TMO_IN_USE;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [USE_BITS-1:0] per_set [PHASES];
		logic [USE_BITS-1:0] tmo_set [PHASES];
		per_set = '{4'd8, 4'd0, 4'd9, 4'd15, 4'd1, 4'd0, 4'd3};
		tmo_set = '{4'd8, 4'd15, 4'd0, 4'd15, 4'd7, 4'd0, 4'd8};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_START_PER, 3'd0, 16'h0001));
		issue(make_cmd(OP_START_PER, 3'd7, 16'h0000));
		issue(make_cmd(OP_START_PER, 3'd3, 16'hFFFF));
		issue(make_cmd(OP_START_TMO, 3'd0, 16'h0001));
		issue(make_cmd(OP_START_TMO, 3'd7, 16'hFFFF));
		issue(make_cmd(OP_START_TMO, 3'd5, 16'h0000));
		issue(make_cmd(OP_TICK,      3'd7, 16'hFFFF));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_START_PER, 3'd0, 16'h0002));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_CLR_TERM,  3'd0, 16'h0000));
		issue(make_cmd(OP_CLR_TERM,  3'd7, 16'hFFFF));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_START_PER, 3'd2, 16'h5555));
		issue(make_cmd(OP_START_TMO, 3'd2, 16'hAAAA));
		issue(make_cmd(OP_START_TMO, 3'd3, 16'h0002));
		issue(make_cmd(OP_START_PER, 3'd5, 16'h0003));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_TICK,      3'd0, 16'h0000));
		issue(make_cmd(OP_CLR_TERM,  3'd5, 16'h0000));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 5)
				write_use(USE_BITS'($urandom_range(0, 15)), USE_BITS'($urandom_range(0, 15)));
			else
				write_use(per_set[p], tmo_set[p]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n % 40 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				issue(random_cmd());
			end
			settle();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_walk.sv
rtl/periodic_and_timeout_timer_table_core.sv
tb/sv/timer_table_checker.sv
tb/sv/tb_periodic_and_timeout_timer_table_core.sv
